// ===== sv/regulator_voltage_code_converter_assert.svh =====
// Assertion macros shared by the converter RTL.
`ifndef REGULATOR_VOLTAGE_CODE_CONVERTER_ASSERT_SVH
`define REGULATOR_VOLTAGE_CODE_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RVCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvcc: same-cycle check failed");
// next-cycle implication
`define RVCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvcc: next-cycle check failed");
`else
`define RVCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RVCC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rvcc_pkg.sv =====
`default_nettype none

package rvcc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_LIMITS = 3'd0;
  localparam logic [2:0] REG_LAYOUT = 3'd1;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_SEG0   = 3'd3;
  localparam int NUM_SEG_REGS = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 49;

  // command codes
  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // serial divider sizing
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = 5;

  localparam logic [7:0] ENABLE_ONE = 8'h01;

  typedef struct packed {
    logic        inv;
    logic [15:0] step;
    logic [15:0] hi;
    logic [15:0] lo;
  } seg_t;

  typedef struct packed {
    logic [15:0] vmax;
    logic [15:0] vmin;
    logic [2:0]  ebit;
    logic [2:0]  shift;
    logic [7:0]  mask;
    logic [2:0]  count;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load_cur;
    logic load_next;
    logic start_q;
    logic start_size;
    logic advance;
    logic fin_nomatch;
    logic fin_set;
    logic fin_get;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic walk;
    logic seg_ok;
    logic match;
    logic div_done;
    logic get_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/rvcc_cfg.sv =====
`default_nettype none

module rvcc_cfg #(
  parameter int SEGMENTS = 4,
  localparam int ADDR_W = $clog2(SEGMENTS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [rvcc_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [rvcc_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic [ADDR_W-1:0]                  rd_addr,
  output rvcc_pkg::cfg_t                     cfg,
  output rvcc_pkg::seg_t                     rd_seg,
  output logic                               rd_ok
);

  rvcc_pkg::seg_t segs [SEGMENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
      for (int k = 0; k < SEGMENTS; k++) begin
        segs[k] <= '0;
      end
    end else if (wr_en) begin
      case (wr_index)
        rvcc_pkg::REG_LIMITS: begin
          cfg.vmin <= wr_data[15:0];
          cfg.vmax <= wr_data[31:16];
        end
        rvcc_pkg::REG_LAYOUT: begin
          cfg.mask  <= wr_data[7:0];
          cfg.shift <= wr_data[10:8];
          cfg.ebit  <= wr_data[13:11];
        end
        rvcc_pkg::REG_COUNT: begin
          cfg.count <= wr_data[2:0];
        end
        default: begin
        end
      endcase
      for (int k = 0; k < SEGMENTS; k++) begin
        if (k < rvcc_pkg::NUM_SEG_REGS && wr_index == rvcc_pkg::REG_SEG0 + 3'(k)) begin
          segs[k] <= rvcc_pkg::seg_t'(wr_data);
        end
      end
    end
  end

  // one read port; an address past the table reads as an empty segment
  always_comb begin
    rd_seg = '0;
    for (int k = 0; k < SEGMENTS; k++) begin
      if (rd_addr == ADDR_W'(k)) begin
        rd_seg = segs[k];
      end
    end
  end

  assign rd_ok = (32'(rd_addr) < 32'(cfg.count)) && (32'(rd_addr) < 32'(SEGMENTS))
                 && (rd_seg.step != '0);

endmodule

`default_nettype wire

// ===== sv/rvcc_div.sv =====
`default_nettype none

module rvcc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rvcc_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [rvcc_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [rvcc_pkg::DIV_NUM_W-1:0] quotient
);

  localparam int NW = rvcc_pkg::DIV_NUM_W;
  localparam int DW = rvcc_pkg::DIV_DEN_W;

  logic [DW-1:0]                  den;
  logic [DW-1:0]                  rem;
  logic [rvcc_pkg::DIV_CNT_W-1:0] cnt;
  logic [DW:0]                    trial;
  logic [DW+1:0]                  diff;

  // restoring step: one quotient bit per cycle, dividend shifts out of quotient
  assign trial = {rem, quotient[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == rvcc_pkg::DIV_CNT_W'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rvcc_pkg::DIV_CNT_W'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (!diff[DW+1]) begin
        rem      <= diff[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b1};
      end else begin
        rem      <= trial[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rvcc_dp.sv =====
`default_nettype none
`include "regulator_voltage_code_converter_assert.svh"

module rvcc_dp (
  input  logic                clk,
  input  logic                rst,
  input  rvcc_pkg::dp_cmd_t   cmd,
  output rvcc_pkg::dp_stat_t  stat,
  input  rvcc_pkg::cfg_t      cfg,
  input  rvcc_pkg::seg_t      seg,
  input  logic                seg_ok,
  input  logic                command,
  input  logic [15:0]         target_mv,
  input  logic signed [1:0]   power_request,
  input  logic [7:0]          cfg_byte,
  input  logic [7:0]          ctrl_byte,
  output logic [7:0]          new_cfg_byte,
  output logic                cfg_write,
  output logic [7:0]          new_ctrl_byte,
  output logic                ctrl_write,
  output logic [15:0]         voltage_mv,
  output logic                status
);

  // captured item
  logic        op;
  logic        tgt_nz;
  logic [15:0] t_cl;
  logic [1:0]  pr;
  logic [7:0]  cfgb;
  logic [7:0]  ctrlb;

  // walk state
  rvcc_pkg::seg_t cur;
  logic [15:0]    nlo;
  logic [7:0]     base;
  logic           neg;

  // pending result
  logic [7:0]  res_cfg;
  logic        res_cfg_w;
  logic [15:0] res_volt;
  logic        res_status;

  logic [15:0] t_clamp;
  logic [7:0]  ebit_mask;
  logic [7:0]  code_get;
  logic [15:0] t_eff;
  logic [16:0] q_num;
  logic [17:0] size_num;
  logic [16:0] q_mag;
  logic [17:0] size_mag;
  logic        div_start;
  logic [16:0] div_dividend;
  logic        div_busy;
  logic        div_done;
  logic [16:0] div_quot;
  logic [7:0]  q8;
  logic [7:0]  b1;
  logic [7:0]  code_set;
  logic [7:0]  code_sh;
  logic [7:0]  reg_set;
  logic [8:0]  diff9;
  logic [15:0] diff16;
  logic [15:0] prod;
  logic        ctrl_upd;
  logic [7:0]  ctrl_res;

  assign t_clamp = (target_mv < cfg.vmin) ? cfg.vmin :
                   (target_mv > cfg.vmax) ? cfg.vmax : target_mv;

  assign ebit_mask = rvcc_pkg::ENABLE_ONE << cfg.ebit;
  assign code_get  = (cfgb & cfg.mask) >> cfg.shift;

  // a target in the gap above this segment snaps to its top
  assign t_eff = (t_cl > cur.hi && t_cl < nlo) ? cur.hi : t_cl;

  assign q_num    = {1'b0, t_eff} - {1'b0, cur.lo};
  assign size_num = {2'b00, cur.hi} - {2'b00, cur.lo} + {2'b00, cur.step};
  assign q_mag    = q_num[16] ? (~q_num + 17'd1) : q_num;
  assign size_mag = size_num[17] ? (~size_num + 18'd1) : size_num;

  assign div_start    = cmd.start_q || cmd.start_size;
  assign div_dividend = cmd.start_q ? q_mag : size_mag[16:0];

  rvcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cur.step),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // truncating signed quotient, kept modulo 256
  assign q8 = neg ? (~div_quot[7:0] + 8'd1) : div_quot[7:0];
  assign b1 = base + q8;

  assign code_set = base + q8;
  assign code_sh  = code_set << cfg.shift;
  assign reg_set  = ((cfgb & ~cfg.mask) | code_sh) ^ (cur.inv ? cfg.mask : 8'h00);

  assign diff9  = {1'b0, code_get} - {1'b0, base};
  assign diff16 = {{7{diff9[8]}}, diff9};
  assign prod   = diff16 * cur.step;

  assign ctrl_upd = (op == rvcc_pkg::CMD_SET) && !pr[1];
  assign ctrl_res = (pr == 2'b00) ? (ctrlb & ~ebit_mask) : (ctrlb | ebit_mask);

  assign stat.walk     = (op == rvcc_pkg::CMD_GET) ? ((ctrlb & ebit_mask) != 8'h00)
                                                   : (tgt_nz && cfg.vmin != 16'h0000);
  assign stat.seg_ok   = seg_ok;
  assign stat.match    = (op == rvcc_pkg::CMD_SET) && (cur.hi >= t_eff);
  assign stat.div_done = div_done;
  assign stat.get_hit  = (op == rvcc_pkg::CMD_GET) && (code_get < b1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= command;
      tgt_nz     <= target_mv != 16'h0000;
      t_cl       <= t_clamp;
      pr         <= power_request;
      cfgb       <= cfg_byte;
      ctrlb      <= ctrl_byte;
      base       <= '0;
      res_cfg    <= cfg_byte;
      res_cfg_w  <= 1'b0;
      res_volt   <= '0;
      res_status <= 1'b0;
    end
    if (cmd.load_cur) begin
      cur <= seg;
    end
    if (cmd.load_next) begin
      nlo <= seg_ok ? seg.lo : 16'h0000;
    end
    if (cmd.start_q) begin
      neg <= q_num[16];
    end else if (cmd.start_size) begin
      neg <= size_num[17];
    end
    if (cmd.advance) begin
      base <= b1;
    end
    if (cmd.fin_nomatch) begin
      if (op == rvcc_pkg::CMD_GET) begin
        res_status <= 1'b1;
      end else begin
        res_cfg   <= cfgb & ~cfg.mask;
        res_cfg_w <= 1'b1;
      end
    end
    if (cmd.fin_set) begin
      res_cfg   <= reg_set;
      res_cfg_w <= 1'b1;
    end
    if (cmd.fin_get) begin
      res_volt <= prod + cur.lo;
    end
    if (cmd.emit) begin
      new_cfg_byte  <= res_cfg;
      cfg_write     <= res_cfg_w;
      new_ctrl_byte <= ctrl_upd ? ctrl_res : ctrlb;
      ctrl_write    <= ctrl_upd;
      voltage_mv    <= res_volt;
      status        <= res_status;
    end
  end

  `RVCC_ASSERT_IMP(a_div_start_idle, clk, rst, div_start, !div_busy)
  `RVCC_ASSERT_IMP(a_div_den_nonzero, clk, rst, div_start, cur.step != 16'h0000)
  `RVCC_ASSERT_IMP(a_get_no_cfg_write, clk, rst, cmd.emit && op == rvcc_pkg::CMD_GET, !res_cfg_w)

endmodule

`default_nettype wire

// ===== sv/rvcc_ctrl.sv =====
`default_nettype none
`include "regulator_voltage_code_converter_assert.svh"

module rvcc_ctrl #(
  parameter int SEGMENTS = 4,
  localparam int ADDR_W = $clog2(SEGMENTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rvcc_pkg::dp_cmd_t  cmd,
  input  rvcc_pkg::dp_stat_t stat,
  output logic [ADDR_W-1:0]  seg_addr
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_NEXT   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIVS   = 3'd5;
  localparam logic [2:0] S_DIVQ   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] seg_idx;
  logic [ADDR_W-1:0] seg_idx_next;

  always_comb begin
    state_next   = state;
    seg_idx_next = seg_idx;
    cmd          = '0;
    in_ready     = 1'b0;
    seg_addr     = seg_idx;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cmd.capture  = 1'b1;
          seg_idx_next = '0;
          state_next   = S_START;
        end
      end
      S_START: begin
        state_next = stat.walk ? S_LOAD : S_EMIT;
      end
      S_LOAD: begin
        if (!stat.seg_ok) begin
          cmd.fin_nomatch = 1'b1;
          state_next      = S_EMIT;
        end else begin
          cmd.load_cur = 1'b1;
          state_next   = S_NEXT;
        end
      end
      S_NEXT: begin
        // peek at the following segment for the gap check
        seg_addr      = seg_idx + ADDR_W'(1);
        cmd.load_next = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.match) begin
          cmd.start_q = 1'b1;
          state_next  = S_DIVQ;
        end else begin
          cmd.start_size = 1'b1;
          state_next     = S_DIVS;
        end
      end
      S_DIVS: begin
        if (stat.div_done) begin
          if (stat.get_hit) begin
            cmd.fin_get = 1'b1;
            state_next  = S_EMIT;
          end else begin
            cmd.advance  = 1'b1;
            seg_idx_next = seg_idx + ADDR_W'(1);
            state_next   = S_LOAD;
          end
        end
      end
      S_DIVQ: begin
        if (stat.div_done) begin
          cmd.fin_set = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      seg_idx <= seg_idx_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RVCC_ASSERT_IMP(a_idx_bound, clk, rst, 1'b1, 32'(seg_idx) <= 32'(SEGMENTS))
  `RVCC_ASSERT_IMP(a_done_when_waiting, clk, rst, stat.div_done, state == S_DIVS || state == S_DIVQ)

endmodule

`default_nettype wire

// ===== sv/regulator_voltage_code_converter.sv =====
// Regulator voltage code converter.
// Input channel (in_valid/in_ready): one command per transfer. A set
// command encodes target_mv into the voltage register byte and updates the
// enable bit if power_request >= 0; get decodes the voltage from the bytes.
// Output channel (out_valid/out_ready): one result per input item.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is ready
// out of reset; write it only while no command is in flight.
// No segment walk is needed for a set with zero target or zero minimum or a
// get with enable clear; otherwise the segment table is walked, with one
// more segment read when the walk runs off the table.
// Each visited segment costs one segment read, one read of its successor,
// a decision step and a run of the bit-serial divider. One item is in work
// at a time; the next is accepted the cycle after the previous result is
// handed to the output register.
// A stalled receiver holds out_valid and the result; the next item may be
// accepted meanwhile but waits before its own result is loaded.
// Reset clears all configuration registers (segment table empty) and both
// channels' valid state.
`default_nettype none

module regulator_voltage_code_converter #(
  parameter int SEGMENTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [15:0]                      target_mv,
  input  logic signed [1:0]                power_request,
  input  logic [7:0]                       cfg_byte,
  input  logic [7:0]                       ctrl_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       new_cfg_byte,
  output logic                             cfg_write,
  output logic [7:0]                       new_ctrl_byte,
  output logic                             ctrl_write,
  output logic [15:0]                      voltage_mv,
  output logic                             status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rvcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rvcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(SEGMENTS + 1);

  rvcc_pkg::cfg_t     cfg;
  rvcc_pkg::seg_t     rd_seg;
  logic               rd_ok;
  logic [ADDR_W-1:0]  seg_addr;
  rvcc_pkg::dp_cmd_t  cmd;
  rvcc_pkg::dp_stat_t stat;

  assign cfg_ready = !rst;

  rvcc_cfg #(.SEGMENTS(SEGMENTS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_addr  (seg_addr),
    .cfg      (cfg),
    .rd_seg   (rd_seg),
    .rd_ok    (rd_ok)
  );

  rvcc_ctrl #(.SEGMENTS(SEGMENTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .seg_addr  (seg_addr)
  );

  rvcc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .seg           (rd_seg),
    .seg_ok        (rd_ok),
    .command       (command),
    .target_mv     (target_mv),
    .power_request (power_request),
    .cfg_byte      (cfg_byte),
    .ctrl_byte     (ctrl_byte),
    .new_cfg_byte  (new_cfg_byte),
    .cfg_write     (cfg_write),
    .new_ctrl_byte (new_ctrl_byte),
    .ctrl_write    (ctrl_write),
    .voltage_mv    (voltage_mv),
    .status        (status)
  );

endmodule

`default_nettype wire
